FILE: rtl/sjea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjea_pkg
// shared types, codes and the double-byte offset function of the glyph
// addresser
// ----------------------------------------------------------------------------
package sjea_pkg;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_SJIS = 2'd1;
  localparam logic [1:0] MODE_EUC  = 2'd2;

  localparam int CMDQ_AW    = 1;              // depth kept a power of two
  localparam int CMDQ_DEPTH = 1 << CMDQ_AW;

  localparam logic [15:0] HALF_W      = 16'd8;
  localparam logic [31:0] HALF_BYTES  = 32'd16;
  localparam logic [31:0] KANJI_BASE  = 32'd4096;

  // one queued draw job: single glyph or a left/right pair
  typedef struct packed {
    logic [31:0] offset;
    logic [15:0] x;
    logic        dbl;
  } cmd_t;

  function automatic logic is_lead(input logic [7:0] b, input logic [1:0] mode);
    logic res;
    if (mode == MODE_SJIS) begin
      res = (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc);
    end else begin
      res = (b >= 8'h81 && b <= 8'hfe);
    end
    return res;
  endfunction

  // row/cell to font offset, all arithmetic modulo 2^32
  function automatic logic [31:0] dbl_offset(input logic [7:0] lead,
                                             input logic [7:0] trail,
                                             input logic [1:0] mode);
    logic signed [9:0]  lead_s;
    logic signed [9:0]  trail_s;
    logic signed [9:0]  k;
    logic signed [9:0]  t;
    logic signed [15:0] v;
    logic signed [31:0] v32;
    lead_s  = signed'({2'b00, lead});
    trail_s = signed'({2'b00, trail});
    if (mode == MODE_SJIS) begin
      if (lead >= 8'h81 && lead <= 8'h9f) begin
        k = (lead_s - 10'sd129) * 10'sd2;
      end else begin
        k = (lead_s - 10'sd224) * 10'sd2 + 10'sd62;
      end
      if (trail >= 8'h40 && trail <= 8'h7e) begin
        t = trail_s - 10'sd64;
      end else if (trail >= 8'h80 && trail <= 8'h9e) begin
        t = trail_s - 10'sd128 + 10'sd63;
      end else begin
        t = trail_s - 10'sd159;
        k = k + 10'sd1;
      end
    end else begin
      k = lead_s - 10'sd161;
      t = trail_s - 10'sd161;
    end
    v   = 16'(k) * 16'sd94 + 16'(t);
    v32 = 32'(v);
    return KANJI_BASE + {v32[26:0], 5'b00000};
  endfunction

endpackage

FILE: rtl/sjea_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjea_front
// accepts text bytes, tracks pen and lead byte, queues draw jobs
// ----------------------------------------------------------------------------
module sjea_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,
  input  logic                 in_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output sjea_pkg::cmd_t       q_cmd
);
  import sjea_pkg::*;

  logic [1:0]  mode_r;
  logic [7:0]  lead_r, lead_nxt;
  logic [15:0] pen_r, pen_nxt;
  logic [15:0] pen_cur;
  logic [7:0]  b;
  logic        acc;
  logic        active;

  assign b         = in_tdata[7:0];
  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign pen_cur   = in_tuser ? {1'b0, in_tdata[22:8]} : pen_r;
  assign active    = (mode_r == MODE_SJIS || mode_r == MODE_EUC) && (b != 8'h00);

  always_comb begin
    lead_nxt     = lead_r;
    pen_nxt      = pen_r;
    q_push       = 1'b0;
    q_cmd.offset = {20'd0, b, 4'd0};
    q_cmd.x      = pen_cur;
    q_cmd.dbl    = 1'b0;
    if (acc) begin
      pen_nxt = active ? pen_cur + HALF_W : pen_cur;
      if (active) begin
        if (lead_r == 8'h00) begin
          if (is_lead(b, mode_r)) begin
            lead_nxt = b;
          end else begin
            q_push = 1'b1;
          end
        end else begin
          lead_nxt     = 8'h00;
          q_push       = 1'b1;
          q_cmd.dbl    = 1'b1;
          q_cmd.offset = dbl_offset(lead_r, b, mode_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OFF;
      lead_r <= 8'h00;
      pen_r  <= 16'd0;
    end else begin
      if (cfg_valid) begin
        mode_r <= cfg_data;
      end
      lead_r <= lead_nxt;
      pen_r  <= pen_nxt;
    end
  end

  // a lead byte is only ever held in a decoding mode range
  a_lead_range: assert property (@(posedge clk) disable iff (!rst_n)
    lead_r == 8'h00 || lead_r >= 8'h81)
    else $error("held lead byte below 0x81");

endmodule

FILE: rtl/sjea_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjea_cmd_fifo
// short job queue between front and back
// ----------------------------------------------------------------------------
module sjea_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sjea_pkg::cmd_t       push_cmd,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output sjea_pkg::cmd_t       head
);
  import sjea_pkg::*;

  cmd_t               slot_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_r, rd_r;
  logic [CMDQ_AW:0]   cnt_r;

  assign full  = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("job queue underflow");

endmodule

FILE: rtl/sjea_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjea_back
// turns queued jobs into one or two glyph draws on the result stream
// ----------------------------------------------------------------------------
module sjea_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  sjea_pkg::cmd_t       q_head,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata,
  output logic                 out_tlast
);
  import sjea_pkg::*;

  logic        vld_r;
  logic [31:0] off_r;
  logic [15:0] x_r;
  logic        last_r;
  logic        second_r;      // right half still to send
  logic [31:0] hold_off_r;
  logic [15:0] hold_x_r;
  logic        slot_free;

  assign slot_free  = !vld_r || out_tready;
  assign q_pop      = slot_free && !second_r && !q_empty;
  assign out_tvalid = vld_r;
  assign out_tdata  = {x_r, off_r};
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (second_r) begin
        off_r  <= hold_off_r;
        x_r    <= hold_x_r;
        last_r <= 1'b1;
      end else if (!q_empty) begin
        off_r      <= q_head.offset;
        x_r        <= q_head.dbl ? q_head.x - HALF_W : q_head.x;
        last_r     <= !q_head.dbl;
        hold_off_r <= q_head.offset + HALF_BYTES;
        hold_x_r   <= q_head.x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      second_r <= 1'b0;
    end else if (slot_free) begin
      if (second_r) begin
        vld_r    <= 1'b1;
        second_r <= 1'b0;
      end else begin
        vld_r    <= !q_empty;
        second_r <= !q_empty && q_head.dbl;
      end
    end
  end

  // a left half is always followed at once by its right half
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("left half not followed by right half");

  a_second_shown: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> vld_r && !last_r)
    else $error("right half pending without a shown left half");

endmodule

FILE: rtl/shift_jis_euc_glyph_addresser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_jis_euc_glyph_addresser
// text bytes in, font glyph draw addresses out (Shift-JIS / EUC-JP / off)
// ----------------------------------------------------------------------------
// Each accepted text byte gives zero, one or two draw transfers. In off mode
// (cfg_data 0 or 3) and for a zero byte nothing is drawn and the pen stays;
// tuser still reloads the pen from start_x. A lead byte is held and gives no
// draw, a single byte draws at byte*16, and the following trail byte draws a
// left half at pen-8 and a right half at pen, at 4096+(row*94+cell)*32 and 16
// bytes on. Rate: the input takes one byte per cycle while the two-entry job
// queue has room; the result side sends one draw per cycle while out_tready
// is high. The mode may be written only while the block is idle; cfg_ready
// is always high.
// ----------------------------------------------------------------------------
module shift_jis_euc_glyph_addresser (
  input  logic        clk,
  input  logic        rst_n,
  // mode register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,    // lang_mode
  // text byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // [7:0] char_byte, [22:8] start_x, [23] zero
  input  logic        in_tuser,    // new_string
  // glyph draw stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [31:0] glyph_offset, [47:32] draw_x
  output logic        out_tlast    // last_of_run
);
  import sjea_pkg::*;

  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_cmd, q_head;

  assign cfg_ready = 1'b1;

  // front: byte classification, pen and lead tracking
  sjea_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  // job queue lets the front run on while a pair is being sent
  sjea_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // back: output register, splits pairs into two transfers
  sjea_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
